// File: rtl/blue_blob_centroid_defines.svh
// Assertion macros for the blue blob centroid block.
`ifndef BLUE_BLOB_CENTROID_DEFINES_SVH
`define BLUE_BLOB_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bbc_pkg.sv
// Package: types and constants of the blue blob centroid block.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

  localparam int ChanW    = 8;
  localparam int CoordW   = 11;
  localparam int SumW     = 33;
  localparam int CntW     = 23;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;
  localparam int QCntW    = 3;

  localparam logic [ChanW-1:0] ThreshReset = 8'd100;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last_in_frame;
  } pix_t;

  typedef struct packed {
    logic              mask;
    logic              frame_done;
    logic [CoordW-1:0] centroid_col;
    logic [CoordW-1:0] centroid_row;
    logic              centroid_found;
  } res_t;

  typedef struct packed {
    logic            mask;
    logic            last;
    logic [SumW-1:0] col_sum;
    logic [SumW-1:0] row_sum;
    logic [CntW-1:0] count;
  } qent_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] col_sum;
    logic [SumW-1:0] row_sum;
    logic [CntW-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] q_col;
    logic [CoordW-1:0] q_row;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/bbc_front.sv
// Front end: pixel test, threshold register and per-frame accumulators.
`timescale 1ns / 1ps
`default_nettype none
module bbc_front import bbc_pkg::*; #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ChanW-1:0] cfg_data_i,
  input  wire logic             accept_i,
  input  wire pix_t             pix_i,
  output qent_t                 ent_o
);

  localparam logic [13:0]       MaxDimW  = 14'(MAX_DIM);
  localparam logic [CoordW-1:0] ClampVal = CoordW'(MAX_DIM - 1);

  logic [ChanW-1:0]  thresh_q;
  logic [SumW-1:0]   col_sum_q, col_sum_d;
  logic [SumW-1:0]   row_sum_q, row_sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CoordW-1:0] col_c, row_c;
  logic [ChanW:0]    rg_sum;
  logic              marked;

  always_comb begin
    col_c = pix_i.col;
    row_c = pix_i.row;
    if ({3'b0, pix_i.col} >= MaxDimW) begin
      col_c = ClampVal;
    end
    if ({3'b0, pix_i.row} >= MaxDimW) begin
      row_c = ClampVal;
    end
    rg_sum = {1'b0, pix_i.red} + {1'b0, pix_i.green};
    marked = (rg_sum < {1'b0, pix_i.blue}) && (pix_i.blue > thresh_q);
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    cnt_d     = cnt_q;
    if (marked) begin
      col_sum_d = col_sum_q + {{(SumW-CoordW){1'b0}}, col_c};
      row_sum_d = row_sum_q + {{(SumW-CoordW){1'b0}}, row_c};
      cnt_d     = cnt_q + 1'b1;
    end
    ent_o.mask    = marked;
    ent_o.last    = pix_i.last_in_frame;
    ent_o.col_sum = col_sum_d;
    ent_o.row_sum = row_sum_d;
    ent_o.count   = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= ThreshReset;
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_data_i;
      end
      if (accept_i) begin
        if (pix_i.last_in_frame) begin
          col_sum_q <= '0;
          row_sum_q <= '0;
          cnt_q     <= '0;
        end else begin
          col_sum_q <= col_sum_d;
          row_sum_q <= row_sum_d;
          cnt_q     <= cnt_d;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bbc_fifo.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bbc_fifo import bbc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t push_ent_i,
  input  wire logic  pop_i,
  output qent_t      head_o,
  output logic       full_o,
  output logic       empty_o
);

  qent_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bbc_div.sv
// Restoring divider: both coordinate sums by one count, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bbc_div import bbc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int                 StepW     = $clog2(SumW + 1);
  localparam logic [StepW-1:0]   StepsInit = StepW'(SumW);

  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q;
  logic [SumW-1:0]   dvd_col_q, dvd_row_q;
  logic [CntW-1:0]   rem_col_q, rem_row_q, rem_col_d, rem_row_d;
  logic [CntW-1:0]   dvs_q;
  logic [CoordW-1:0] q_col_q, q_row_q;
  logic [CntW:0]     sh_col, sh_row;
  logic              ge_col, ge_row;

  always_comb begin
    sh_col    = {rem_col_q, dvd_col_q[SumW-1]};
    sh_row    = {rem_row_q, dvd_row_q[SumW-1]};
    ge_col    = (sh_col >= {1'b0, dvs_q});
    ge_row    = (sh_row >= {1'b0, dvs_q});
    rem_col_d = ge_col ? CntW'(sh_col - {1'b0, dvs_q}) : CntW'(sh_col);
    rem_row_d = ge_row ? CntW'(sh_row - {1'b0, dvs_q}) : CntW'(sh_row);
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.q_col = q_col_q;
  assign rsp_o.q_row = q_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= StepsInit;
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_col_q <= req_i.col_sum;
      dvd_row_q <= req_i.row_sum;
      dvs_q     <= req_i.count;
      rem_col_q <= '0;
      rem_row_q <= '0;
      q_col_q   <= '0;
      q_row_q   <= '0;
    end else if (busy_q) begin
      dvd_col_q <= {dvd_col_q[SumW-2:0], 1'b0};
      dvd_row_q <= {dvd_row_q[SumW-2:0], 1'b0};
      rem_col_q <= rem_col_d;
      rem_row_q <= rem_row_d;
      q_col_q   <= {q_col_q[CoordW-2:0], ge_col};
      q_row_q   <= {q_row_q[CoordW-2:0], ge_row};
    end
  end

endmodule
`default_nettype wire

// File: rtl/bbc_back.sv
// Back end: frame-end sequencing, held centroid and output register.
`timescale 1ns / 1ps
`default_nettype none
module bbc_back import bbc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire qent_t    head_i,
  input  wire logic     empty_i,
  output logic          pop_o,
  output div_req_t      div_req_o,
  input  wire div_rsp_t div_rsp_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output res_t          out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  res_t              out_q;
  logic [CoordW-1:0] last_col_q, last_row_q;
  logic              slot_free, needs_div;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign needs_div = head_i.last && (head_i.count != '0);

  always_comb begin
    pop_o = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = !empty_i && !needs_div && slot_free;
      ST_FIN:  pop_o = slot_free;
      default: pop_o = 1'b0;
    endcase
    div_req_o.start   = (state_q == ST_IDLE) && !empty_i && needs_div;
    div_req_o.col_sum = head_i.col_sum;
    div_req_o.row_sum = head_i.row_sum;
    div_req_o.count   = head_i.count;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      last_col_q  <= '0;
      last_row_q  <= '0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            if (needs_div) begin
              state_q <= ST_DIV;
            end else if (slot_free) begin
              out_valid_q          <= 1'b1;
              out_q.mask           <= head_i.mask;
              out_q.frame_done     <= head_i.last;
              out_q.centroid_col   <= head_i.last ? last_col_q : '0;
              out_q.centroid_row   <= head_i.last ? last_row_q : '0;
              out_q.centroid_found <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp_i.done) begin
            last_col_q <= div_rsp_i.q_col;
            last_row_q <= div_rsp_i.q_row;
            state_q    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_q          <= 1'b1;
            out_q.mask           <= head_i.mask;
            out_q.frame_done     <= 1'b1;
            out_q.centroid_col   <= last_col_q;
            out_q.centroid_row   <= last_row_q;
            out_q.centroid_found <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/blue_blob_centroid.sv
// Pixels needing no division pass through the queue register and then the output register.
// A frame end with marked pixels also waits for the 33-step bit-serial divider.
// Throughput: one word per cycle unless the queue is full; the back end holds the frame-end
// word during the division while a 4-word queue keeps the front accepting until it fills.
// Reset: async active low; clears sums, count, held centroid, queue; threshold to 100.
`timescale 1ns / 1ps
`default_nettype none
`include "blue_blob_centroid_defines.svh"
module blue_blob_centroid import bbc_pkg::*; #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ChanW-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pix_t             in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output res_t                  out_word_o
);

  logic     accept;
  qent_t    ent, head;
  logic     q_full, q_empty, pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bbc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .pix_i      (in_word_i),
    .ent_o      (ent)
  );

  bbc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_ent_i (ent),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  bbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  `BBC_ASSERT_NOW(a_mid_frame_zero, out_valid_o && !out_word_o.frame_done, (out_word_o.centroid_col == '0) && (out_word_o.centroid_row == '0) && !out_word_o.centroid_found, "mid-frame word carries centroid data")
  `BBC_ASSERT_NOW(a_found_at_end, out_valid_o && out_word_o.centroid_found, out_word_o.frame_done, "centroid found outside frame end")
  `BBC_ASSERT_NOW(a_pop_not_empty, pop, !q_empty, "queue popped while empty")
  `BBC_ASSERT_NEXT(a_div_ack, div_req.start, !pop, "queue popped while division runs")

endmodule
`default_nettype wire
